// File: hw/rtl/tsd_pkg.sv
// tsd_pkg: shared types, codes and constants for the touch swipe detector.
// Used by tsd_step, touch_swipe_detector and tsd_checker; no dependencies.

package tsd_pkg;

	localparam int unsigned MAX_FINGERS_DEF = 10;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned CFG_DATA_W      = 32;

	localparam logic [14:0] TAN20_Q16 = 15'd23853;

	localparam logic [15:0] MIN_TRAVEL_RST   = 16'd1280;
	localparam logic [15:0] DRIFT_ALLOW_RST  = 16'd256;
	localparam logic [31:0] MAX_DURATION_RST = 32'd500000000;

	localparam logic [3:0] DIR_LEFT  = 4'b0001;
	localparam logic [3:0] DIR_RIGHT = 4'b0010;
	localparam logic [3:0] DIR_UP    = 4'b0100;
	localparam logic [3:0] DIR_DOWN  = 4'b1000;
	localparam logic [3:0] DIR_ALL   = 4'b1111;
	localparam logic [3:0] FINGERS_MAX = 4'd15;

	typedef enum logic [1:0] {
		OP_DOWN   = 2'd0,
		OP_UP     = 2'd1,
		OP_MOVE   = 2'd2,
		OP_UPDATE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_TRAVEL   = 2'd0,
		CFG_DRIFT_ALLOW  = 2'd1,
		CFG_MAX_DURATION = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] min_travel;
		logic [15:0] drift_allowance;
		logic [31:0] max_duration;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  finger_index;
		logic [15:0] cur_x;
		logic [15:0] cur_y;
		logic [15:0] prev_x;
		logic [15:0] prev_y;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic        is_moving;
		logic [31:0] elapsed_ns;
	} item_t;

	typedef struct packed {
		logic [3:0] active_fingers;
		logic       gesture_done;
		logic       swipe_seen;
		logic [3:0] candidate_dirs;
	} state_t;

	typedef struct packed {
		logic        accepted;
		logic        swipe_found;
		logic [3:0]  swipe_dirs;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] end_x;
		logic [15:0] end_y;
		logic [3:0]  finger_count;
	} result_t;

endpackage

// File: hw/rtl/tsd_step.sv
// tsd_step: per-event decision logic, purely combinational.
// Takes the registered event, gesture state and config; depends on tsd_pkg.

module tsd_step import tsd_pkg::*; #(
	parameter int unsigned MAX_FINGERS = MAX_FINGERS_DEF
) (
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  st_nxt,
	output result_t res
);

	localparam logic [3:0] MaxIdx = 4'(MAX_FINGERS);

	logic [15:0] dx, dy;
	logic [30:0] tx_prod, ty_prod;
	logic [32:0] rhs_y, rhs_x;
	logic        ybad, xbad;
	logic [3:0]  step_mask, dirs1, dirs2;
	logic        seen_hit;
	logic        move_ok;
	logic [3:0]  af_inc, af_dec;
	op_t         op;

	assign op = op_t'(item.op);

	assign dx = (item.cur_x > item.origin_x) ? item.cur_x - item.origin_x
	                                         : item.origin_x - item.cur_x;
	assign dy = (item.cur_y > item.origin_y) ? item.cur_y - item.origin_y
	                                         : item.origin_y - item.cur_y;

	// drift * 2^16 > travel * tan20 + allowance * 2^16
	assign ty_prod = 31'(dx * TAN20_Q16);
	assign tx_prod = 31'(dy * TAN20_Q16);
	assign rhs_y   = {2'b0, ty_prod} + {1'b0, cfg.drift_allowance, 16'b0};
	assign rhs_x   = {2'b0, tx_prod} + {1'b0, cfg.drift_allowance, 16'b0};
	assign ybad    = {1'b0, dy, 16'b0} > rhs_y;
	assign xbad    = {1'b0, dx, 16'b0} > rhs_x;

	// steps against a direction remove it
	always_comb begin
		step_mask = DIR_ALL;
		if (item.cur_x > item.prev_x)
			step_mask = step_mask & ~DIR_LEFT;
		else if (item.cur_x < item.prev_x)
			step_mask = step_mask & ~DIR_RIGHT;
		if (item.cur_y > item.prev_y)
			step_mask = step_mask & ~DIR_UP;
		else if (item.cur_y < item.prev_y)
			step_mask = step_mask & ~DIR_DOWN;
	end

	assign dirs1 = st.candidate_dirs & step_mask;
	assign dirs2 = dirs1 & ~{xbad, xbad, ybad, ybad};
	assign seen_hit = ((dirs1[0] | dirs1[1]) & ~ybad & (dx > cfg.min_travel)) |
	                  ((dirs1[2] | dirs1[3]) & ~xbad & (dy > cfg.min_travel));

	assign move_ok = (item.finger_index < st.active_fingers) & ~st.gesture_done &
	                 item.is_moving;

	assign af_inc = (st.active_fingers < FINGERS_MAX) ? st.active_fingers + 4'd1
	                                                  : st.active_fingers;
	assign af_dec = (st.active_fingers != 4'd0) ? st.active_fingers - 4'd1
	                                            : st.active_fingers;

	always_comb begin
		st_nxt = st;
		res    = '0;
		if (item.finger_index < MaxIdx) begin
			case (op)
				OP_DOWN: begin
					st_nxt.active_fingers = af_inc;
					if (af_inc <= 4'd1) begin
						st_nxt.gesture_done   = 1'b0;
						st_nxt.swipe_seen     = 1'b0;
						st_nxt.candidate_dirs = DIR_ALL;
					end
					res.accepted = 1'b1;
				end
				OP_UP: begin
					st_nxt.active_fingers = af_dec;
					if (!st.gesture_done) begin
						st_nxt.gesture_done = 1'b1;
						if (st.swipe_seen && st.candidate_dirs != 4'd0 &&
						    item.elapsed_ns <= cfg.max_duration) begin
							res.accepted     = 1'b1;
							res.swipe_found  = 1'b1;
							res.swipe_dirs   = st.candidate_dirs;
							res.start_x      = item.origin_x;
							res.start_y      = item.origin_y;
							res.end_x        = item.cur_x;
							res.end_y        = item.cur_y;
							res.finger_count = af_dec + 4'd1;
						end
					end
				end
				OP_MOVE, OP_UPDATE: begin
					if (op == OP_UPDATE && st.gesture_done) begin
						res.accepted = 1'b1;
					end else if (move_ok) begin
						if (dirs1 == 4'd0) begin
							st_nxt.candidate_dirs = dirs1;
							st_nxt.gesture_done   = 1'b1;
						end else begin
							st_nxt.candidate_dirs = dirs2;
							st_nxt.swipe_seen     = st.swipe_seen | seen_hit;
							st_nxt.gesture_done   = (dirs2 == 4'd0);
							res.accepted          = (dirs2 != 4'd0);
						end
					end
				end
				default: begin
					st_nxt = st;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/touch_swipe_detector.sv
// touch_swipe_detector: top level, request registers, gesture state and config.
// Depends on tsd_pkg and tsd_step.

// Swipe recognizer for a stream of touch events. Each accepted event gives
// exactly one result. An event is taken into an input register, decided by
// one pass of compare and constant-multiply logic against the gesture state,
// and the result lands in an output register. out_valid rises when the event
// moves from the input register to the output register, which waits while a
// stalled result is held there. One event per cycle is sustained while the
// output side takes results. in_stall rises only while the output register
// holds a stalled result and the input register is full. Configuration is
// written through wr_en/wr_index/wr_data and should only change while idle.

module touch_swipe_detector import tsd_pkg::*; #(
	parameter int unsigned MAX_FINGERS = MAX_FINGERS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [3:0]            finger_index,
	input  logic [15:0]           cur_x,
	input  logic [15:0]           cur_y,
	input  logic [15:0]           prev_x,
	input  logic [15:0]           prev_y,
	input  logic [15:0]           origin_x,
	input  logic [15:0]           origin_y,
	input  logic                  is_moving,
	input  logic [31:0]           elapsed_ns,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic                  swipe_found,
	output logic [3:0]            swipe_dirs,
	output logic [15:0]           start_x,
	output logic [15:0]           start_y,
	output logic [15:0]           end_x,
	output logic [15:0]           end_y,
	output logic [3:0]            finger_count
);

	cfg_t    cfg_q;
	state_t  st_q, st_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res, res_s2;
	logic    valid_s2;
	logic    adv, in_acc;

	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_travel      <= MIN_TRAVEL_RST;
			cfg_q.drift_allowance <= DRIFT_ALLOW_RST;
			cfg_q.max_duration    <= MAX_DURATION_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_MIN_TRAVEL:   cfg_q.min_travel      <= wr_data[15:0];
				CFG_DRIFT_ALLOW:  cfg_q.drift_allowance <= wr_data[15:0];
				CFG_MAX_DURATION: cfg_q.max_duration    <= wr_data[31:0];
				default:          cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '{active_fingers: 4'd0, gesture_done: 1'b0,
			              swipe_seen: 1'b0, candidate_dirs: DIR_ALL};
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= '{op: op, finger_index: finger_index, cur_x: cur_x,
			             cur_y: cur_y, prev_x: prev_x, prev_y: prev_y,
			             origin_x: origin_x, origin_y: origin_y,
			             is_moving: is_moving, elapsed_ns: elapsed_ns};
		end
		if (adv)
			res_s2 <= res;
	end

	tsd_step #(
		.MAX_FINGERS(MAX_FINGERS)
	) u_step (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.st_nxt (st_nxt),
		.res    (res)
	);

	assign out_valid    = valid_s2;
	assign accepted     = res_s2.accepted;
	assign swipe_found  = res_s2.swipe_found;
	assign swipe_dirs   = res_s2.swipe_dirs;
	assign start_x      = res_s2.start_x;
	assign start_y      = res_s2.start_y;
	assign end_x        = res_s2.end_x;
	assign end_y        = res_s2.end_y;
	assign finger_count = res_s2.finger_count;

endmodule

// File: hw/rtl/tsd_checker.sv
// tsd_checker: port-level assertions for touch_swipe_detector, with its bind.
// Depends on tsd_pkg and the top level's port list.

module tsd_checker import tsd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        accepted,
	input logic        swipe_found,
	input logic [3:0]  swipe_dirs,
	input logic [15:0] start_x,
	input logic [15:0] start_y,
	input logic [15:0] end_x,
	input logic [15:0] end_y,
	input logic [3:0]  finger_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(swipe_found) &&
		$stable(swipe_dirs) && $stable(finger_count) && $stable(accepted))
		else $error("stalled result changed");

	a_found_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && swipe_found |-> accepted && swipe_dirs != 4'd0)
		else $error("swipe reported without acceptance or direction");

	a_no_swipe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !swipe_found |-> swipe_dirs == 4'd0 && start_x == 16'd0 &&
		start_y == 16'd0 && end_x == 16'd0 && end_y == 16'd0 &&
		finger_count == 4'd0)
		else $error("swipe fields set without a swipe");

	// a fresh result follows a taken request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching request");

endmodule

bind touch_swipe_detector tsd_checker u_tsd_checker (.*);

// File: sim/tb_top.sv
// tb_top: self-checking bench for touch_swipe_detector; a gesture tracker in the bench
// predicts every result from the touch events and register writes seen at the ports.
// Depends on tsd_pkg and the touch_swipe_detector RTL.
`timescale 1ns / 100ps

module tb_top;
	import tsd_pkg::*;

	localparam int RUN_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            op = '0;
	logic [3:0]            finger_index = '0;
	logic [15:0]           cur_x = '0;
	logic [15:0]           cur_y = '0;
	logic [15:0]           prev_x = '0;
	logic [15:0]           prev_y = '0;
	logic [15:0]           origin_x = '0;
	logic [15:0]           origin_y = '0;
	logic                  is_moving = 1'b0;
	logic [31:0]           elapsed_ns = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b1;
	logic                  accepted;
	logic                  swipe_found;
	logic [3:0]            swipe_dirs;
	logic [15:0]           start_x;
	logic [15:0]           start_y;
	logic [15:0]           end_x;
	logic [15:0]           end_y;
	logic [3:0]            finger_count;

	touch_swipe_detector u_dut (.*);

	// gesture tracker state and its copy of the registers
	logic [3:0]  trk_fingers = '0;
	logic        trk_done = 1'b0;
	logic        trk_seen = 1'b0;
	logic [3:0]  trk_dirs = DIR_ALL;
	logic [15:0] trk_min_travel = MIN_TRAVEL_RST;
	logic [15:0] trk_allow = DRIFT_ALLOW_RST;
	logic [31:0] trk_max_dur = MAX_DURATION_RST;

	item_t   touch_q[$];
	result_t gesture_q[$];
	item_t   tx_touch;
	result_t predicted;
	result_t got;

	int  touches_queued = 0;
	int  touches_taken = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	int  tx_wait = 0;
	bit  tx_steady = 1'b0;
	bit  in_taken = 1'b0;
	bit  out_taken = 1'b0;
	int  rx_clk = 0;
	int  rx_wait = 0;
	int  rx_hold = 0;

	// stimulus-side view of finger count and registers
	int          gen_fingers = 0;
	logic [15:0] gen_min = MIN_TRAVEL_RST;
	logic [31:0] gen_max = MAX_DURATION_RST;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit drift_exceeds(input logic [15:0] drift, input logic [15:0] travel);
		logic [63:0] lhs, rhs, tr, al;
		lhs = {32'd0, drift, 16'd0};
		tr = {48'd0, travel};
		al = {32'd0, trk_allow, 16'd0};
		rhs = tr * TAN20_Q16 + al;
		return lhs > rhs;
	endfunction

	function automatic bit track_move(input item_t t);
		logic [15:0] dx, dy;
		bit xbad, ybad;
		if (t.finger_index >= trk_fingers || trk_done || !t.is_moving)
			return 1'b0;
		if (t.cur_x > t.prev_x) trk_dirs &= ~DIR_LEFT;
		else if (t.cur_x < t.prev_x) trk_dirs &= ~DIR_RIGHT;
		if (t.cur_y > t.prev_y) trk_dirs &= ~DIR_UP;
		else if (t.cur_y < t.prev_y) trk_dirs &= ~DIR_DOWN;
		if (trk_dirs == 4'd0) begin
			trk_done = 1'b1;
			return 1'b0;
		end
		dx = (t.cur_x > t.origin_x) ? t.cur_x - t.origin_x : t.origin_x - t.cur_x;
		dy = (t.cur_y > t.origin_y) ? t.cur_y - t.origin_y : t.origin_y - t.cur_y;
		ybad = drift_exceeds(dy, dx);
		xbad = drift_exceeds(dx, dy);
		// horizontal directions die on vertical drift and vice versa
		if (trk_dirs & DIR_LEFT) begin
			if (ybad) trk_dirs &= ~DIR_LEFT;
			else if (dx > trk_min_travel) trk_seen = 1'b1;
		end
		if (trk_dirs & DIR_RIGHT) begin
			if (ybad) trk_dirs &= ~DIR_RIGHT;
			else if (dx > trk_min_travel) trk_seen = 1'b1;
		end
		if (trk_dirs & DIR_UP) begin
			if (xbad) trk_dirs &= ~DIR_UP;
			else if (dy > trk_min_travel) trk_seen = 1'b1;
		end
		if (trk_dirs & DIR_DOWN) begin
			if (xbad) trk_dirs &= ~DIR_DOWN;
			else if (dy > trk_min_travel) trk_seen = 1'b1;
		end
		if (trk_dirs == 4'd0) begin
			trk_done = 1'b1;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic swipe_step(input item_t t, output result_t r);
		r = '0;
		if (t.finger_index >= MAX_FINGERS_DEF)
			return;
		case (op_t'(t.op))
			OP_DOWN: begin
				if (trk_fingers != FINGERS_MAX) trk_fingers++;
				if (trk_fingers <= 4'd1) begin
					trk_done = 1'b0;
					trk_seen = 1'b0;
					trk_dirs = DIR_ALL;
				end
				r.accepted = 1'b1;
			end
			OP_UP: begin
				if (trk_fingers != 4'd0) trk_fingers--;
				if (!trk_done) begin
					trk_done = 1'b1;
					if (trk_seen && trk_dirs != 4'd0 && t.elapsed_ns <= trk_max_dur) begin
						r.accepted = 1'b1;
						r.swipe_found = 1'b1;
						r.swipe_dirs = trk_dirs;
						r.start_x = t.origin_x;
						r.start_y = t.origin_y;
						r.end_x = t.cur_x;
						r.end_y = t.cur_y;
						r.finger_count = trk_fingers + 4'd1;
					end
				end
			end
			OP_MOVE: r.accepted = track_move(t);
			default: r.accepted = trk_done ? 1'b1 : track_move(t);
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] actual,
			input logic [31:0] want);
		if (actual !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, actual);
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (touch_q.size() != 0) begin
				tx_touch = touch_q.pop_front();
				op <= tx_touch.op;
				finger_index <= tx_touch.finger_index;
				cur_x <= tx_touch.cur_x;
				cur_y <= tx_touch.cur_y;
				prev_x <= tx_touch.prev_x;
				prev_y <= tx_touch.prev_y;
				origin_x <= tx_touch.origin_x;
				origin_y <= tx_touch.origin_y;
				is_moving <= tx_touch.is_moving;
				elapsed_ns <= tx_touch.elapsed_ns;
				in_valid <= 1'b1;
				tx_wait = tx_steady ? 0 : $urandom_range(0, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: per-result stall, quiet stretches, and a long hold now and then
	always @(negedge clk) begin
		rx_clk++;
		if (rx_clk % 1500 == 700)
			rx_hold = 80;
		if (out_taken)
			rx_wait = ((rx_clk / 400) % 4 == 0) ? 0 : $urandom_range(0, 9);
		if (rx_hold > 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: tracker update on accepted requests, compare on taken results
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) begin
				if (wr_index == CFG_MIN_TRAVEL) trk_min_travel = wr_data[15:0];
				else if (wr_index == CFG_DRIFT_ALLOW) trk_allow = wr_data[15:0];
				else if (wr_index == CFG_MAX_DURATION) trk_max_dur = wr_data;
			end
			in_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				swipe_step({op, finger_index, cur_x, cur_y, prev_x, prev_y, origin_x, origin_y,
					is_moving, elapsed_ns}, predicted);
				gesture_q.push_back(predicted);
				touches_taken++;
			end
			if (out_valid && !out_stall) begin
				got = {accepted, swipe_found, swipe_dirs, start_x, start_y, end_x, end_y,
					finger_count};
				if (gesture_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing outstanding", $realtime);
				end else begin
					predicted = gesture_q.pop_front();
					check_field("accepted", 32'(got.accepted), 32'(predicted.accepted));
					check_field("swipe_found", 32'(got.swipe_found),
						32'(predicted.swipe_found));
					check_field("swipe_dirs", 32'(got.swipe_dirs), 32'(predicted.swipe_dirs));
					check_field("start_x", 32'(got.start_x), 32'(predicted.start_x));
					check_field("start_y", 32'(got.start_y), 32'(predicted.start_y));
					check_field("end_x", 32'(got.end_x), 32'(predicted.end_x));
					check_field("end_y", 32'(got.end_y), 32'(predicted.end_y));
					check_field("finger_count", 32'(got.finger_count),
						32'(predicted.finger_count));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int clamp16(input int v);
		return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
	endfunction

	task automatic add_touch(input op_t o, input int idx, input int cx, input int cy,
			input int px, input int py, input int ox, input int oy, input bit mv,
			input logic [31:0] el);
		item_t t;
		t.op = o;
		t.finger_index = idx[3:0];
		t.cur_x = cx[15:0];
		t.cur_y = cy[15:0];
		t.prev_x = px[15:0];
		t.prev_y = py[15:0];
		t.origin_x = ox[15:0];
		t.origin_y = oy[15:0];
		t.is_moving = mv;
		t.elapsed_ns = el;
		if (idx < MAX_FINGERS_DEF) begin
			if (o == OP_DOWN && gen_fingers < 15) gen_fingers++;
			if (o == OP_UP && gen_fingers > 0) gen_fingers--;
		end
		touch_q.push_back(t);
		touches_queued++;
	endtask

	task automatic add_noise();
		add_touch(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1) != 0,
			$urandom);
	endtask

	// pile up fingers past the count limit, then lift a few
	task automatic add_storm();
		int n, k;
		n = $urandom_range(15, 20);
		for (k = 0; k < n; k++)
			add_touch(OP_DOWN, $urandom_range(0, 9), $urandom_range(0, 65535),
				$urandom_range(0, 65535), 0, 0, 0, 0, 1'b0, 0);
		n = $urandom_range(1, 4);
		for (k = 0; k < n; k++)
			add_touch(OP_UP, $urandom_range(0, 9), 0, 0, 0, 0, 0, 0, 1'b1, $urandom);
	endtask

	// one well-formed gesture: lift leftovers, touch down, a few moves, lift
	task automatic add_swipe();
		int dir, n, k, ox, oy, x, y, px, py, stp, jit, idx, fingers;
		logic [31:0] el;
		tx_steady = ($urandom_range(0, 5) == 0);
		while (gen_fingers > 0)
			add_touch(OP_UP, $urandom_range(0, 9), $urandom_range(0, 65535),
				$urandom_range(0, 65535), 0, 0, 0, 0, 1'b1, $urandom);
		ox = $urandom_range(8000, 57000);
		oy = $urandom_range(8000, 57000);
		add_touch(OP_DOWN, 0, ox, oy, ox, oy, ox, oy, 1'b0, 0);
		fingers = 1;
		if ($urandom_range(0, 4) == 0) begin
			add_touch(OP_DOWN, 1, ox, oy, ox, oy, ox, oy, 1'b0, 0);
			fingers = 2;
		end
		dir = $urandom_range(0, 3);
		n = $urandom_range(1, 6);
		x = ox;
		y = oy;
		el = 0;
		for (k = 0; k < n; k++) begin
			px = x;
			py = y;
			stp = $urandom_range(16, (gen_min / 2 + 400 > 8000) ? 8000 : gen_min / 2 + 400);
			if ($urandom_range(0, 9) == 0) stp = -stp;
			jit = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3000) - 1500 :
				$urandom_range(0, 40) - 20;
			case (dir)
				0: begin x = clamp16(x - stp); y = clamp16(y + jit); end
				1: begin x = clamp16(x + stp); y = clamp16(y + jit); end
				2: begin y = clamp16(y - stp); x = clamp16(x + jit); end
				default: begin y = clamp16(y + stp); x = clamp16(x + jit); end
			endcase
			el += $urandom_range(1000000, 60000000);
			idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, fingers - 1);
			add_touch(($urandom_range(0, 3) == 0) ? OP_UPDATE : OP_MOVE, idx, x, y, px, py, ox, oy,
				$urandom_range(0, 15) != 0, el);
		end
		case ($urandom_range(0, 7))
			0: el = gen_max;
			1: el = gen_max + 1;
			2: el = $urandom;
			default: el = $urandom_range(0, gen_max);
		endcase
		add_touch(OP_UP, $urandom_range(0, fingers - 1), x, y, px, py, ox, oy, 1'b1, el);
	endtask

	task automatic run_random(input int count);
		int target, k;
		target = touches_queued + count;
		while (touches_queued < target) begin
			case ($urandom_range(0, 19))
				0: add_storm();
				1, 2, 3, 4, 5: for (k = $urandom_range(1, 3); k > 0; k--) add_noise();
				default: add_swipe();
			endcase
		end
	endtask

	// all requests taken and all results back, then let the pipeline settle
	task automatic wait_idle();
		do @(negedge clk);
		while (touches_taken != touches_queued || gesture_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] mt, input logic [15:0] da,
			input logic [31:0] md);
		wait_idle();
		write_reg(CFG_MIN_TRAVEL, {16'd0, mt});
		write_reg(CFG_DRIFT_ALLOW, {16'd0, da});
		write_reg(CFG_MAX_DURATION, md);
		gen_min = mt;
		gen_max = md;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: ignored pointers, count limits, each op and each rejection path
		add_touch(OP_UP, 0, 65535, 65535, 65535, 65535, 65535, 65535, 1'b1, 32'hffffffff);
		add_touch(OP_MOVE, 0, 100, 100, 0, 0, 0, 0, 1'b1, 5);
		add_touch(OP_DOWN, 15, 0, 0, 0, 0, 0, 0, 1'b0, 0);
		add_touch(OP_UPDATE, 10, 0, 0, 0, 0, 0, 0, 1'b1, 0);
		add_touch(OP_DOWN, 0, 1000, 1000, 1000, 1000, 1000, 1000, 1'b0, 0);
		add_touch(OP_MOVE, 0, 4000, 1000, 1000, 1000, 1000, 1000, 1'b0, 500);
		add_touch(OP_MOVE, 0, 4000, 1000, 1000, 1000, 1000, 1000, 1'b1, 1000);
		add_touch(OP_UPDATE, 0, 5000, 1000, 4000, 1000, 1000, 1000, 1'b1, 2000);
		add_touch(OP_UP, 0, 5000, 1000, 5000, 1000, 1000, 1000, 1'b1, MAX_DURATION_RST);
		add_touch(OP_UPDATE, 0, 5000, 1000, 5000, 1000, 1000, 1000, 1'b1, 0);
		add_touch(OP_UP, 0, 5000, 1000, 5000, 1000, 1000, 1000, 1'b1, 0);
		add_touch(OP_DOWN, 9, 0, 0, 0, 0, 0, 0, 1'b0, 0);
		add_touch(OP_DOWN, 3, 0, 0, 0, 0, 0, 0, 1'b0, 0);
		add_touch(OP_MOVE, 1, 0, 65535, 0, 0, 0, 0, 1'b1, 100);
		add_touch(OP_MOVE, 5, 0, 65535, 0, 65535, 0, 0, 1'b1, 200);
		add_touch(OP_UP, 3, 0, 65535, 0, 65535, 0, 0, 1'b1, MAX_DURATION_RST + 1);
		add_touch(OP_UP, 9, 0, 65535, 0, 65535, 0, 0, 1'b1, 0);
		add_touch(OP_DOWN, 0, 30000, 30000, 30000, 30000, 30000, 30000, 1'b0, 0);
		add_touch(OP_MOVE, 0, 31000, 31000, 30000, 30000, 30000, 30000, 1'b1, 10);
		add_touch(OP_UPDATE, 0, 31000, 31000, 31000, 31000, 30000, 30000, 1'b1, 20);
		add_touch(OP_UP, 0, 31000, 31000, 31000, 31000, 30000, 30000, 1'b1, 30);
		add_touch(OP_DOWN, 0, 65535, 65535, 65535, 65535, 65535, 65535, 1'b0, 0);
		add_touch(OP_MOVE, 0, 0, 65535, 65535, 65535, 65535, 65535, 1'b1, 0);
		add_touch(OP_DOWN, 1, 0, 65535, 0, 65535, 65535, 65535, 1'b0, 0);
		add_touch(OP_UP, 1, 0, 65535, 0, 65535, 65535, 65535, 1'b1, 0);
		add_touch(OP_UP, 0, 0, 65535, 0, 65535, 65535, 65535, 1'b1, 0);

		run_random(250);
		set_config(16'd0, 16'd0, 32'd0);
		run_random(120);
		set_config(16'hffff, 16'hffff, 32'hffffffff);
		run_random(100);
		set_config(16'($urandom_range(200, 3000)), 16'($urandom_range(0, 1000)), $urandom);
		run_random(230);
		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
